// ===== rtl/hrrn_pkg.sv =====
// ----------------------------------------------------------------------------
// HRRN scheduler package
// Shared types, codes and defaults for the task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package hrrn_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 16;

    localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    localparam logic [2:0] ST_ADDED    = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_DISPATCH = 3'd2;
    localparam logic [2:0] ST_IDLE     = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    typedef struct packed {
        logic        action;
        logic [7:0]  task_id;
        logic [15:0] arrival_time;
        logic [15:0] service_time;
    } request_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  chosen_id;
        logic [31:0] start_time;
        logic [31:0] finish_time;
    } result_t;

    typedef struct packed {
        logic [7:0]  label;
        logic [15:0] arrival;
        logic [15:0] service;
    } entry_t;

endpackage

`default_nettype wire

// ===== rtl/hrrn_ram.sv =====
// ----------------------------------------------------------------------------
// HRRN generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hrrn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AddrW-1:0] wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AddrW-1:0] rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/hrrn_task_scheduler_top.sv =====
// Add, table-full reject and step on an empty table give their result in the cycle
// after the request; busy stays low.
// Step: S_LOAD loads the oldest entry; S_EVAL passes each later entry that is skipped or
// wins a tie rule, else S_EVAL, S_MULB and S_CMP do a ratio compare on the shared
// multiplier; S_FINAL decides; the result follows, then S_SHIFT moves entries down, busy high.
// Results cannot be stalled. Reset clears count, time and controller, not the table RAM.
// ----------------------------------------------------------------------------
// HRRN task scheduler top level
// Task table in RAM, one sequencer and one shared ratio multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module hrrn_task_scheduler_top #(
    parameter int TABLE_DEPTH = hrrn_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire hrrn_pkg::request_t request,
    output logic                   busy,
    output logic                   done,
    output hrrn_pkg::result_t      result
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W  = ADDR_W + 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOAD  = 7'b0000010,
        S_EVAL  = 7'b0000100,
        S_MULB  = 7'b0001000,
        S_CMP   = 7'b0010000,
        S_FINAL = 7'b0100000,
        S_SHIFT = 7'b1000000
    } state_t;

    state_t                 state_reg,  state_next;
    logic [CNT_W-1:0]       count_reg,  count_next;
    logic [31:0]            now_reg,    now_next;
    logic                   done_reg,   done_next;
    hrrn_pkg::result_t      result_reg, result_next;
    logic [ADDR_W-1:0]      idx_reg,    idx_next;
    logic [ADDR_W-1:0]      cidx_reg,   cidx_next;
    hrrn_pkg::entry_t       cand_reg,   cand_next;
    hrrn_pkg::entry_t       ent_reg,    ent_next;
    logic signed [50:0]     proda_reg,  proda_next;
    logic signed [50:0]     prodb_reg,  prodb_next;

    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    hrrn_pkg::entry_t       wr_data;
    logic [ADDR_W-1:0]      rd_addr;
    hrrn_pkg::entry_t       rd_data;

    logic [15:0]            n_arr;
    logic [15:0]            n_serv;
    logic signed [33:0]     n_val;
    logic [15:0]            mul_s;
    logic signed [50:0]     mul_p;

    logic [CMP_W-1:0]       count_ext;
    logic [CMP_W-1:0]       idx_inc;
    logic [CMP_W-1:0]       idx_inc2;
    logic [CMP_W-1:0]       cidx_inc;
    logic [32:0]            finish_sum;
    logic [31:0]            finish_sat;
    logic                   accept;
    logic                   table_full;

    hrrn_ram #(
        .WIDTH($bits(hrrn_pkg::entry_t)),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    assign accept     = start && !busy;
    assign table_full = (count_reg == CNT_W'(TABLE_DEPTH));
    assign count_ext  = CMP_W'(count_reg);
    assign idx_inc    = CMP_W'(idx_reg) + CMP_W'(1);
    assign idx_inc2   = CMP_W'(idx_reg) + CMP_W'(2);
    assign cidx_inc   = CMP_W'(cidx_reg) + CMP_W'(1);
    assign finish_sum = {1'b0, now_reg} + {17'b0, cand_reg.service};
    assign finish_sat = finish_sum[32] ? hrrn_pkg::TIME_MAX : finish_sum[31:0];

    always_comb
    begin
        if (state_reg == S_MULB)
        begin
            n_arr  = ent_reg.arrival;
            n_serv = ent_reg.service;
            mul_s  = cand_reg.service;
        end
        else
        begin
            n_arr  = cand_reg.arrival;
            n_serv = cand_reg.service;
            mul_s  = rd_data.service;
        end
    end

    assign n_val = signed'({2'b00, now_reg} - {18'b0, n_arr} + {18'b0, n_serv});
    assign mul_p = 51'(n_val) * 51'(signed'({1'b0, mul_s}));

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        now_next    = now_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        idx_next    = idx_reg;
        cidx_next   = cidx_reg;
        cand_next   = cand_reg;
        ent_next    = ent_reg;
        proda_next  = proda_reg;
        prodb_next  = prodb_reg;
        wr_en       = 1'b0;
        wr_addr     = count_reg[ADDR_W-1:0];
        wr_data     = hrrn_pkg::entry_t'({request.task_id, request.arrival_time,
                                          request.service_time});
        rd_addr     = idx_inc[ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr  = '0;
                idx_next = '0;
                if (accept)
                begin
                    result_next = '0;
                    if (request.action == hrrn_pkg::ACT_ADD)
                    begin
                        done_next = 1'b1;
                        if (table_full)
                        begin
                            result_next.status = hrrn_pkg::ST_FULL;
                        end
                        else
                        begin
                            wr_en              = 1'b1;
                            count_next         = count_reg + CNT_W'(1);
                            result_next.status = hrrn_pkg::ST_ADDED;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        done_next          = 1'b1;
                        result_next.status = hrrn_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        state_next = S_LOAD;
                    end
                end
            end

            S_LOAD:
            begin
                cand_next = rd_data;
                cidx_next = '0;
                idx_next  = idx_inc[ADDR_W-1:0];
                state_next = (idx_inc < count_ext) ? S_EVAL : S_FINAL;
            end

            S_EVAL:
            begin
                ent_next   = rd_data;
                proda_next = mul_p;
                if ({16'b0, rd_data.arrival} > now_reg)
                begin
                    idx_next   = idx_inc[ADDR_W-1:0];
                    state_next = (idx_inc < count_ext) ? S_EVAL : S_FINAL;
                end
                else if ((cand_reg.arrival == rd_data.arrival &&
                          cand_reg.service > rd_data.service) ||
                         (cand_reg.service == rd_data.service &&
                          cand_reg.arrival > rd_data.arrival))
                begin
                    cand_next  = rd_data;
                    cidx_next  = idx_reg;
                    idx_next   = idx_inc[ADDR_W-1:0];
                    state_next = (idx_inc < count_ext) ? S_EVAL : S_FINAL;
                end
                else
                begin
                    state_next = S_MULB;
                end
            end

            S_MULB:
            begin
                prodb_next = mul_p;
                state_next = S_CMP;
            end

            S_CMP:
            begin
                if (proda_reg < prodb_reg)
                begin
                    cand_next = ent_reg;
                    cidx_next = idx_reg;
                end
                idx_next   = idx_inc[ADDR_W-1:0];
                state_next = (idx_inc < count_ext) ? S_EVAL : S_FINAL;
            end

            S_FINAL:
            begin
                done_next   = 1'b1;
                result_next = '0;
                rd_addr     = cidx_inc[ADDR_W-1:0];
                idx_next    = cidx_reg;
                state_next  = S_IDLE;
                if ({16'b0, cand_reg.arrival} > now_reg)
                begin
                    result_next.status = hrrn_pkg::ST_IDLE;
                    if (now_reg != hrrn_pkg::TIME_MAX)
                    begin
                        now_next = now_reg + 32'd1;
                    end
                end
                else
                begin
                    result_next.status      = hrrn_pkg::ST_DISPATCH;
                    result_next.chosen_id   = cand_reg.label;
                    result_next.start_time  = now_reg;
                    result_next.finish_time = finish_sat;
                    now_next                = finish_sat;
                    count_next              = count_reg - CNT_W'(1);
                    if (cidx_inc < count_ext)
                    begin
                        state_next = S_SHIFT;
                    end
                end
            end

            S_SHIFT:
            begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg;
                wr_data  = rd_data;
                rd_addr  = idx_inc2[ADDR_W-1:0];
                idx_next = idx_inc[ADDR_W-1:0];
                if (!(idx_inc < count_ext))
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            now_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            now_reg   <= now_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        idx_reg    <= idx_next;
        cidx_reg   <= cidx_next;
        cand_reg   <= cand_next;
        ent_reg    <= ent_next;
        proda_reg  <= proda_next;
        prodb_reg  <= prodb_next;
    end

`ifndef SYNTHESIS
    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && request.action == hrrn_pkg::ACT_ADD && table_full)
        |=> (done && result.status == hrrn_pkg::ST_FULL && count_reg == $past(count_reg)))
        else $error("add to a full table not rejected");

    a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && request.action == hrrn_pkg::ACT_STEP && count_reg != '0)
        |=> (busy && !done))
        else $error("step on a non-empty table did not start a scan");

    a_time_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (now_reg >= $past(now_reg)))
        else $error("time counter moved backward");

    a_finish_order: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == hrrn_pkg::ST_DISPATCH)
        |-> (result.finish_time >= result.start_time && now_reg == result.finish_time))
        else $error("dispatch times inconsistent");
`endif

endmodule

`default_nettype wire
